// ----- hw/rtl/meshlet_local_index_builder_defines.svh -----
// Assertion helpers for the RTL files; only mlib_back.sv includes them.
`ifndef MESHLET_LOCAL_INDEX_BUILDER_DEFINES_SVH
`define MESHLET_LOCAL_INDEX_BUILDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MLIB_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLIB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/mlib_pkg.sv -----
package mlib_pkg;

    localparam int GV_W        = 32;
    localparam int LOC_W       = 8;
    localparam int CNT_OUT_W   = 7;
    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_SUMMARY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE,
        S_EMIT
    } t_back_state;

    // One classified index: corner is its slot within the current triangle.
    typedef struct packed {
        logic [GV_W-1:0] gv;
        logic            end_c;
        logic [1:0]      corner;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        t_kind                kind;
        logic [GV_W-1:0]      value;
        logic [CNT_OUT_W-1:0] vtx_cnt;
        logic [CNT_OUT_W-1:0] tri_cnt;
        logic [GV_W-1:0]      vtx_base;
        logic [GV_W-1:0]      tri_base;
        logic                 overflow;
        logic                 last;
    } t_result;

endpackage

// ----- hw/rtl/mlib_front.sv -----
module mlib_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,   // global_vertex[31:0]
    input  logic                  i_s_tlast,   // end_of_cluster
    input  mlib_pkg::t_qstat      i_qstat,
    output mlib_pkg::t_push       o_push
);
    import mlib_pkg::*;

    logic [1:0] r_corner;
    logic [1:0] n_corner;
    logic       accept;

    assign o_s_tready = !i_qstat.full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Corner slot depends only on position in the cluster: 0, 1, 2, repeat.
    always_comb begin
        n_corner = r_corner;
        if (accept) begin
            if (i_s_tlast || r_corner == 2'd2) begin
                n_corner = 2'd0;
            end else begin
                n_corner = r_corner + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= 2'd0;
        end else begin
            r_corner <= n_corner;
        end
    end

    assign o_push.valid       = accept;
    assign o_push.item.gv     = i_s_tdata;
    assign o_push.item.end_c  = i_s_tlast;
    assign o_push.item.corner = r_corner;

endmodule

// ----- hw/rtl/mlib_queue.sv -----
module mlib_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlib_pkg::t_push   i_push,
    input  logic              i_pop,
    output mlib_pkg::t_item   o_head,
    output mlib_pkg::t_qstat  o_qstat
);
    import mlib_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push.valid && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

endmodule

// ----- hw/rtl/mlib_back.sv -----
`include "meshlet_local_index_builder_defines.svh"

module mlib_back #(
    parameter int MAX_LOCAL_VERTICES = 64,
    parameter int MAX_TRIANGLES      = 124
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlib_pkg::t_item   i_head,
    input  mlib_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output mlib_pkg::t_result o_m_res
);
    import mlib_pkg::*;

    localparam int AW = (MAX_LOCAL_VERTICES > 1) ? $clog2(MAX_LOCAL_VERTICES) : 1;
    localparam int CW = $clog2(MAX_LOCAL_VERTICES + 1);
    localparam int TW = $clog2(MAX_TRIANGLES + 1);

    t_back_state r_state, n_state;

    logic [GV_W-1:0]  r_tbl [MAX_LOCAL_VERTICES];
    logic [GV_W-1:0]  r_rd;
    logic [AW-1:0]    rd_addr;

    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    idx_next;
    logic [GV_W-1:0]  r_gv;
    logic             r_end;
    logic [1:0]       r_corner;
    logic             r_found, n_found;
    logic [LOC_W-1:0] r_local, n_local;

    logic [CW-1:0]    r_count, n_count;
    logic [LOC_W-1:0] r_c0, n_c0;
    logic [LOC_W-1:0] r_c1, n_c1;
    logic [TW-1:0]    r_tri, n_tri;
    logic             r_ovf, n_ovf;
    logic [GV_W-1:0]  r_run_v, n_run_v;
    logic [GV_W-1:0]  r_run_t, n_run_t;

    logic             r_pend_v, n_pend_v;
    logic             r_pend_t, n_pend_t;
    logic             r_pend_s, n_pend_s;
    logic [GV_W-1:0]  r_tri_word, n_tri_word;
    logic [CNT_OUT_W-1:0] r_sum_vc, n_sum_vc;
    logic [CNT_OUT_W-1:0] r_sum_tc, n_sum_tc;
    logic [GV_W-1:0]  r_sum_vo, n_sum_vo;
    logic [GV_W-1:0]  r_sum_to, n_sum_to;
    logic             r_res_ovf, n_res_ovf;

    logic             r_m_valid, n_m_valid;
    t_result          r_m_res, n_m_res;

    logic             hit;
    logic             has_room;
    logic             store;
    logic [LOC_W-1:0] loc;
    logic [CW-1:0]    cnt_upd;
    logic [TW-1:0]    tri_upd;
    logic             ovf_upd;
    logic             tri_done;
    logic             out_free;
    logic             any_pend;
    logic             wr_en;

    assign idx_next = r_idx + 1'b1;
    assign hit      = (r_rd == r_gv);
    assign has_room = (r_count < CW'(MAX_LOCAL_VERTICES));
    assign store    = !r_found && has_room;
    assign out_free = !r_m_valid || i_m_ready;
    assign any_pend = r_pend_v || r_pend_t || r_pend_s;
    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;
    assign rd_addr  = (r_state == S_SEARCH) ? idx_next[AW-1:0] : '0;
    assign wr_en    = (r_state == S_RESOLVE) && store;

    // Local table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tbl[r_count[AW-1:0]] <= r_gv;
        end
        r_rd <= r_tbl[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = (r_count == '0) ? S_RESOLVE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit || idx_next == r_count) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = (store || r_corner == 2'd2 || r_end) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free && ((r_pend_v ? 1'b1 : 1'b0) + (r_pend_t ? 1'b1 : 1'b0)
                        + (r_pend_s ? 1'b1 : 1'b0)) <= 2'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Resolve arithmetic.
    always_comb begin
        loc      = r_found ? r_local : (has_room ? LOC_W'(r_count) : '0);
        cnt_upd  = r_count + CW'(store);
        tri_done = (r_corner == 2'd2) && (r_tri < TW'(MAX_TRIANGLES));
        tri_upd  = r_tri + TW'(tri_done);
        ovf_upd  = r_ovf || (!r_found && !has_room)
                   || ((r_corner == 2'd2) && !tri_done);
    end

    // Datapath and output staging.
    always_comb begin
        n_idx      = r_idx;
        n_found    = r_found;
        n_local    = r_local;
        n_count    = r_count;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_tri      = r_tri;
        n_ovf      = r_ovf;
        n_run_v    = r_run_v;
        n_run_t    = r_run_t;
        n_pend_v   = r_pend_v;
        n_pend_t   = r_pend_t;
        n_pend_s   = r_pend_s;
        n_tri_word = r_tri_word;
        n_sum_vc   = r_sum_vc;
        n_sum_tc   = r_sum_tc;
        n_sum_vo   = r_sum_vo;
        n_sum_to   = r_sum_to;
        n_res_ovf  = r_res_ovf;
        n_m_valid  = out_free ? 1'b0 : r_m_valid;
        n_m_res    = r_m_res;

        case (r_state)
            S_IDLE: begin
                n_idx   = '0;
                n_found = 1'b0;
            end
            S_SEARCH: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_local = LOC_W'(r_idx);
                end else begin
                    n_idx = idx_next;
                end
            end
            S_RESOLVE: begin
                n_count    = cnt_upd;
                n_tri      = tri_upd;
                n_ovf      = ovf_upd;
                n_res_ovf  = ovf_upd;
                n_pend_v   = store;
                n_pend_t   = tri_done;
                n_pend_s   = r_end;
                n_tri_word = {8'd0, loc, r_c1, r_c0};
                if (r_corner == 2'd0) begin
                    n_c0 = loc;
                end
                if (r_corner == 2'd1) begin
                    n_c1 = loc;
                end
                n_sum_vc = CNT_OUT_W'(cnt_upd);
                n_sum_tc = CNT_OUT_W'(tri_upd);
                n_sum_vo = r_run_v;
                n_sum_to = r_run_t;
                if (r_end) begin
                    // Close the cluster: advance offsets, clear per-cluster state.
                    n_run_v = r_run_v + GV_W'(cnt_upd);
                    n_run_t = r_run_t + GV_W'(tri_upd);
                    n_count = '0;
                    n_tri   = '0;
                    n_ovf   = 1'b0;
                end
            end
            S_EMIT: begin
                if (out_free && any_pend) begin
                    n_m_valid         = 1'b1;
                    n_m_res.vtx_cnt   = '0;
                    n_m_res.tri_cnt   = '0;
                    n_m_res.vtx_base  = '0;
                    n_m_res.tri_base  = '0;
                    n_m_res.overflow  = r_res_ovf;
                    if (r_pend_v) begin
                        n_m_res.kind  = KIND_VERTEX;
                        n_m_res.value = r_gv;
                        n_m_res.last  = !(r_pend_t || r_pend_s);
                        n_pend_v      = 1'b0;
                    end else if (r_pend_t) begin
                        n_m_res.kind  = KIND_TRIANGLE;
                        n_m_res.value = r_tri_word;
                        n_m_res.last  = !r_pend_s;
                        n_pend_t      = 1'b0;
                    end else begin
                        n_m_res.kind     = KIND_SUMMARY;
                        n_m_res.value    = '0;
                        n_m_res.vtx_cnt  = r_sum_vc;
                        n_m_res.tri_cnt  = r_sum_tc;
                        n_m_res.vtx_base = r_sum_vo;
                        n_m_res.tri_base = r_sum_to;
                        n_m_res.last     = 1'b1;
                        n_pend_s         = 1'b0;
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_tri     <= '0;
            r_ovf     <= 1'b0;
            r_run_v   <= '0;
            r_run_t   <= '0;
            r_c0      <= '0;
            r_c1      <= '0;
            r_pend_v  <= 1'b0;
            r_pend_t  <= 1'b0;
            r_pend_s  <= 1'b0;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tri     <= n_tri;
            r_ovf     <= n_ovf;
            r_run_v   <= n_run_v;
            r_run_t   <= n_run_t;
            r_c0      <= n_c0;
            r_c1      <= n_c1;
            r_pend_v  <= n_pend_v;
            r_pend_t  <= n_pend_t;
            r_pend_s  <= n_pend_s;
            r_m_valid <= n_m_valid;
            r_idx     <= n_idx;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_gv     <= i_head.gv;
            r_end    <= i_head.end_c;
            r_corner <= i_head.corner;
        end
        r_local    <= n_local;
        r_tri_word <= n_tri_word;
        r_sum_vc   <= n_sum_vc;
        r_sum_tc   <= n_sum_tc;
        r_sum_vo   <= n_sum_vo;
        r_sum_to   <= n_sum_to;
        r_res_ovf  <= n_res_ovf;
        r_m_res    <= n_m_res;
    end

    assign o_m_valid = r_m_valid;
    assign o_m_res   = r_m_res;

    `MLIB_ASSERT_IMPL(a_search_in_range, r_state == S_SEARCH, r_idx < r_count, "search past fill")
    `MLIB_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(MAX_LOCAL_VERTICES), "table overfilled")
    `MLIB_ASSERT_IMPL(a_tri_bound, 1'b1, r_tri <= TW'(MAX_TRIANGLES), "triangle count too high")
    `MLIB_ASSERT_IMPL(a_idle_drained, r_state == S_IDLE, !any_pend, "results left pending")
    `MLIB_ASSERT_NEXT(a_pop_starts, o_pop, r_state == S_SEARCH || r_state == S_RESOLVE, "pop lost")

endmodule

// ----- hw/rtl/meshlet_local_index_builder.sv -----
// Builds a cluster's local vertex list and packed triangle words from a stream of
// global vertex indices, one index per input beat (tlast marks the cluster's last
// index). Each index is searched in the local table one entry per cycle through the
// table's single read port: an index leaves the input queue, is compared with the
// local vertices found so far (none while the table is empty; a hit on entry j ends
// the search there), is resolved, and then sends the result beats it causes (0 to 3:
// new vertex, triangle, cluster summary, in that order), or passes through an emit
// step with no beat when its only effect is a dropped triangle. Result beats also
// wait while the receiver holds off. A four-entry queue in front lets the input side
// keep taking beats while the table search runs, and the output register lets the
// search of the next index proceed while a result waits.
module meshlet_local_index_builder #(
    parameter int MAX_LOCAL_VERTICES = 64,
    parameter int MAX_TRIANGLES      = 124
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // global_vertex[31:0]
    input  logic         i_s_tlast,   // end_of_cluster
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // value[31:0], vtx_cnt[38:32], tri_cnt[45:39],
    // vtx_base[77:46], tri_base[109:78], overflow[110], zero[111]
    output logic [111:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,   // kind[1:0]
    output logic         o_m_tlast    // last
);
    import mlib_pkg::*;

    t_push   push;
    t_qstat  qstat;
    t_item   head;
    logic    pop;
    t_result res;

    mlib_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_qstat    (qstat),
        .o_push     (push)
    );

    mlib_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    mlib_back #(
        .MAX_LOCAL_VERTICES (MAX_LOCAL_VERTICES),
        .MAX_TRIANGLES      (MAX_TRIANGLES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_qstat   (qstat),
        .o_pop     (pop),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_m_res   (res)
    );

    assign o_m_tdata = {1'b0, res.overflow, res.tri_base, res.vtx_base,
                        res.tri_cnt, res.vtx_cnt, res.value};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import mlib_pkg::*;

    localparam int MAXV = 64;
    localparam int MAXT = 124;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS = 480;

    typedef enum int {
        SHAPE_REUSE,
        SHAPE_SCATTER,
        SHAPE_TABLE_FULL,
        SHAPE_TRI_LIMIT
    } t_cluster_shape;

    // Tracks the per-cluster vertex table and predicts every result beat.
    class local_index_tracker;
        bit [31:0]   vtx_table [MAXV];
        int unsigned vtx_count;
        int unsigned tri_count;
        int unsigned corner_pos;
        int unsigned corner_loc [2];
        bit [31:0]   run_vertices;
        bit [31:0]   run_triangles;
        bit          ovf;
        t_result     pending_results [$];
        int unsigned mismatches;
        int unsigned strays;
        int unsigned reported;
        int unsigned checked;
        int unsigned kind_seen [3];
        int unsigned ovf_clusters;

        function new();
            clear_cluster();
            run_vertices  = '0;
            run_triangles = '0;
        endfunction

        function void clear_cluster();
            vtx_count     = 0;
            tri_count     = 0;
            corner_pos    = 0;
            corner_loc[0] = 0;
            corner_loc[1] = 0;
            ovf           = 1'b0;
        endfunction

        function t_result make_result(t_kind kind, bit [31:0] value);
            t_result r;
            r                 = '0;
            r.kind            = kind;
            r.value           = value;
            return r;
        endfunction

        function void note_index(bit [31:0] gv, bit eoc);
            t_result     fresh [$];
            t_result     r;
            int unsigned loc_idx;
            bit          hit;
            loc_idx = 0;
            hit     = 1'b0;
            for (int j = 0; j < vtx_count; j++) begin
                if (!hit && vtx_table[j] == gv) begin
                    loc_idx = j;
                    hit     = 1'b1;
                end
            end
            if (!hit) begin
                if (vtx_count < MAXV) begin
                    loc_idx              = vtx_count;
                    vtx_table[vtx_count] = gv;
                    vtx_count++;
                    fresh = {fresh, make_result(KIND_VERTEX, gv)};
                end else begin
                    // table full: corner falls back to local 0
                    ovf     = 1'b1;
                    loc_idx = 0;
                end
            end
            if (corner_pos < 2) begin
                corner_loc[corner_pos] = loc_idx;
                corner_pos++;
            end else begin
                if (tri_count < MAXT) begin
                    tri_count++;
                    fresh = {fresh, make_result(KIND_TRIANGLE,
                        {8'h00, loc_idx[7:0], corner_loc[1][7:0], corner_loc[0][7:0]})};
                end else begin
                    ovf = 1'b1;
                end
                corner_pos = 0;
            end
            if (eoc) begin
                r          = make_result(KIND_SUMMARY, '0);
                r.vtx_cnt  = vtx_count[6:0];
                r.tri_cnt  = tri_count[6:0];
                r.vtx_base = run_vertices;
                r.tri_base = run_triangles;
                fresh = {fresh, r};
            end
            for (int k = 0; k < fresh.size(); k++) begin
                fresh[k].overflow = ovf;
                fresh[k].last     = (k == fresh.size() - 1);
                pending_results   = {pending_results, fresh[k]};
            end
            if (eoc) begin
                if (ovf)
                    ovf_clusters++;
                run_vertices  += vtx_count;
                run_triangles += tri_count;
                clear_cluster();
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                strays++;
                reported++;
                if (reported <= 10)
                    $display("unexpected result beat: kind %0d value %h", got.kind, got.value);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            kind_seen[int'(want.kind)]++;
            if (got.kind !== want.kind || got.value !== want.value
                    || got.vtx_cnt !== want.vtx_cnt
                    || got.tri_cnt !== want.tri_cnt
                    || got.vtx_base !== want.vtx_base
                    || got.tri_base !== want.tri_base
                    || got.overflow !== want.overflow || got.last !== want.last) begin
                mismatches++;
                reported++;
                if (reported <= 10)
                    $display({"beat %0d mismatch (exp/got): kind %0d/%0d value %h/%h ",
                              "vcnt %0d/%0d tcnt %0d/%0d voff %h/%h toff %h/%h ",
                              "ovf %b/%b last %b/%b"},
                             checked, want.kind, got.kind, want.value, got.value,
                             want.vtx_cnt, got.vtx_cnt,
                             want.tri_cnt, got.tri_cnt,
                             want.vtx_base, got.vtx_base,
                             want.tri_base, got.tri_base,
                             want.overflow, got.overflow, want.last, got.last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata;   // global_vertex[31:0]
    logic         i_s_tlast;   // end_of_cluster
    logic         o_m_tvalid;
    logic         i_m_tready;
    // value[31:0], vtx_cnt[38:32], tri_cnt[45:39],
    // vtx_base[77:46], tri_base[109:78], overflow[110], zero[111]
    logic [111:0] o_m_tdata;
    logic [1:0]   o_m_tuser;   // kind[1:0]
    logic         o_m_tlast;   // last

    local_index_tracker sb;
    bit [31:0]          stim_gv [$];
    bit                 stim_eoc [$];
    int unsigned        sent_items;
    int unsigned        cluster_total;
    bit                 held_off;

    meshlet_local_index_builder #(
        .MAX_LOCAL_VERTICES(MAXV),
        .MAX_TRIANGLES     (MAXT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic add_index(bit [31:0] gv, bit eoc);
        stim_gv  = {stim_gv, gv};
        stim_eoc = {stim_eoc, eoc};
    endtask

    // Build one cluster; the end mark always goes on its final index.
    task automatic add_cluster(t_cluster_shape shape, output int len);
        bit [31:0] pool [$];
        int        pool_n;
        int        extra;
        case (shape)
            SHAPE_TABLE_FULL: pool_n = MAXV + $urandom_range(1, 16);
            SHAPE_TRI_LIMIT:  pool_n = $urandom_range(1, 8);
            SHAPE_REUSE:      pool_n = $urandom_range(1, 24);
            default:          pool_n = 0;
        endcase
        for (int i = 0; i < pool_n; i++)
            pool = {pool, 32'($urandom)};
        case (shape)
            SHAPE_TABLE_FULL: begin
                extra = $urandom_range(0, 20);
                len   = pool_n + extra;
                // walk the whole pool first so the table overruns
                for (int i = 0; i < len; i++)
                    add_index(i < pool_n ? pool[i] : pool[$urandom_range(0, pool_n - 1)],
                              i == len - 1);
            end
            SHAPE_TRI_LIMIT: begin
                len = 3 * MAXT + $urandom_range(0, 8);
                for (int i = 0; i < len; i++)
                    add_index(pool[$urandom_range(0, pool_n - 1)], i == len - 1);
            end
            SHAPE_REUSE: begin
                len = $urandom_range(1, 45);
                for (int i = 0; i < len; i++)
                    add_index(pool[$urandom_range(0, pool_n - 1)], i == len - 1);
            end
            default: begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    add_index($urandom, i == len - 1);
            end
        endcase
        cluster_total++;
    endtask

    task automatic send_index(bit [31:0] gv, bit eoc);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= gv;
        i_s_tlast  <= eoc;
        do
            @(posedge i_clk);
        while (o_s_tready !== 1'b1);
        sb.note_index(gv, eoc);
        sent_items++;
    endtask

    task automatic pause_input(int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= $urandom;
        i_s_tlast  <= 1'(($urandom_range(0, 1)));
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Receiver: rotating stall patterns, plus one long hold-off once traffic is flowing.
    initial begin
        int cyc;
        int mode;
        cyc        = 0;
        held_off   = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            mode = (cyc / 50) % 4;
            if (!held_off && sent_items >= 60) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    2:       i_m_tready <= (cyc % 5 != 0) && (cyc % 7 != 0);
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind     = t_kind'(o_m_tuser);
            got.value    = o_m_tdata[31:0];
            got.vtx_cnt  = o_m_tdata[38:32];
            got.tri_cnt  = o_m_tdata[45:39];
            got.vtx_base = o_m_tdata[77:46];
            got.tri_base = o_m_tdata[109:78];
            got.overflow = o_m_tdata[110];
            got.last     = o_m_tlast;
            sb.check_beat(got);
        end
    end

    initial begin
        int             burst_left;
        int             gap;
        int             len;
        int             random_items;
        int             guard;
        int unsigned    fails;
        t_cluster_shape shape;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        sent_items    = 0;
        cluster_total = 0;
        sb = new();

        // extremes, a hit closing a triangle, a triangle plus summary on the end mark
        add_index(32'h0000_0000, 1'b0);
        add_index(32'hFFFF_FFFF, 1'b0);
        add_index(32'h0000_0000, 1'b0);
        add_index(32'hAAAA_AAAA, 1'b0);
        add_index(32'h5555_5555, 1'b0);
        add_index(32'hFFFF_FFFF, 1'b1);
        // new vertex, triangle and summary from one index
        add_index(32'h0000_0001, 1'b0);
        add_index(32'h0000_0002, 1'b0);
        add_index(32'h0000_0003, 1'b1);
        // one leftover corner dropped
        add_index(32'h8000_0000, 1'b1);
        // two leftover corners dropped
        add_index(32'h0000_0007, 1'b0);
        add_index(32'h0000_0007, 1'b1);
        // degenerate triangle, then a hit that only ends the cluster
        add_index(32'h0000_0009, 1'b0);
        add_index(32'h0000_0009, 1'b0);
        add_index(32'h0000_0009, 1'b0);
        add_index(32'h0000_0009, 1'b1);
        cluster_total = 5;

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (cluster_total == 7)
                shape = SHAPE_TABLE_FULL;
            else if (cluster_total == 9)
                shape = SHAPE_TRI_LIMIT;
            else begin
                case ($urandom_range(0, 19))
                    0:       shape = SHAPE_TABLE_FULL;
                    1, 2, 3: shape = SHAPE_SCATTER;
                    default: shape = SHAPE_REUSE;
                endcase
            end
            add_cluster(shape, len);
            random_items += len;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        for (int i = 0; i < stim_gv.size(); i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    pause_input(gap);
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
            end
            send_index(stim_gv[i], stim_eoc[i]);
            burst_left--;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        guard = 0;
        while (sb.outstanding() > 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        // let any stray beat show up
        repeat (300) @(posedge i_clk);

        fails = sb.mismatches + sb.strays + sb.outstanding();
        $display("Drove %0d indices over %0d clusters, %0d of them overflowing; %0d beats checked",
                 sent_items, cluster_total, sb.ovf_clusters, sb.checked);
        $display("Beats: %0d vertex, %0d triangle, %0d summary; %0d mismatched, %0d stray, %0d missing",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
                 sb.mismatches, sb.strays, sb.outstanding());
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
